// File: hdl/gclbb_pkg.sv
// Shared types and constants for the G-code line bounding box unit.
// No dependencies.
package gclbb_pkg;

  localparam int CoordW = 24;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CoordW-1:0]        mag_t;

  // Magnitude saturates one past the positive limit so that a negative
  // value can reach the most negative code.
  localparam mag_t   MagCap = 24'h800000;
  localparam coord_t PosCap = 24'sh7FFFFF;

  localparam logic OpByte  = 1'b0;
  localparam logic OpClear = 1'b1;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChY     = 8'h59;

  localparam logic [1:0] FracMax = 2'd3;

  // Number parser state: magnitude in thousandths plus flags.
  typedef struct packed {
    logic       begun;
    logic       stop;
    logic       dot;
    logic       neg;
    logic [1:0] fcnt;
    mag_t       accum;
  } num_t;

  // Weight of the next fraction digit in thousandths.
  function automatic logic [6:0] frac_weight(input logic [1:0] fcnt);
    logic [6:0] w;
    case (fcnt)
      2'd0:    w = 7'd100;
      2'd1:    w = 7'd10;
      default: w = 7'd1;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/gclbb_in_if.sv
// Input channel of the bounding box unit: op and text byte.
// Depends on nothing.
interface gclbb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, op, ch, input ready);
  modport sink   (input valid, op, ch, output ready);
endinterface

// File: hdl/gclbb_out_if.sv
// Result channel of the bounding box unit: box and line flag.
// Depends on gclbb_pkg.
interface gclbb_out_if;
  import gclbb_pkg::*;

  logic   valid;
  logic   ready;
  coord_t box_x_min;
  coord_t box_x_max;
  coord_t box_y_min;
  coord_t box_y_max;
  logic   line_counted;

  modport source (output valid, box_x_min, box_x_max, box_y_min, box_y_max,
                  line_counted, input ready);
  modport sink   (input valid, box_x_min, box_x_max, box_y_min, box_y_max,
                  line_counted, output ready);
endinterface

// File: hdl/gclbb_num.sv
// Coordinate word parser step: next parser state for one byte, and the
// signed saturated value of the current state. Depends on gclbb_pkg.
module gclbb_num (
  input  gclbb_pkg::num_t   cur,
  input  logic [7:0]        ch,
  output gclbb_pkg::num_t   nxt,
  output gclbb_pkg::coord_t value
);
  import gclbb_pkg::*;

  logic       is_digit;
  logic [3:0] digit;
  logic [27:0] wide;

  assign is_digit = (ch >= ChZero) && (ch <= ChNine);
  assign digit    = ch[3:0];

  always_comb begin
    nxt  = cur;
    wide = 28'(cur.accum);
    if (!cur.stop) begin
      nxt.begun = 1'b1;
      if ((ch == ChPlus || ch == ChMinus) && !cur.begun) begin
        if (ch == ChMinus) nxt.neg = 1'b1;
      end else if (is_digit) begin
        if (!cur.dot) begin
          // accum * 10 + digit * 1000
          wide = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0}
               + 28'(digit) * 28'd1000;
        end else if (cur.fcnt < FracMax) begin
          wide = 28'(cur.accum) + 28'(digit) * 28'(frac_weight(cur.fcnt));
          nxt.fcnt = cur.fcnt + 2'd1;
        end
        nxt.accum = (wide > 28'(MagCap)) ? MagCap : wide[CoordW-1:0];
      end else if (ch == ChDot && !cur.dot) begin
        nxt.dot = 1'b1;
      end else begin
        nxt.stop = 1'b1;
      end
    end
  end

  always_comb begin
    if (cur.neg) begin
      value = coord_t'(-cur.accum);
    end else if (cur.accum > mag_t'(PosCap)) begin
      value = PosCap;
    end else begin
      value = coord_t'(cur.accum);
    end
  end

endmodule

// File: hdl/gcode_line_bounding_box_unit.sv
// G-code X/Y bounding box unit: one byte per cycle, box emitted at each LF.
// A request is registered in the input register, then processed; its result (LF only)
// is loaded into the output register when the request leaves the input register.
// Throughput: one request per cycle; an LF waiting on a stalled result stalls the input.
// Reset (rst, synchronous): box and line state cleared, channels empty.
// Depends on gclbb_pkg, gclbb_in_if, gclbb_out_if, gclbb_num.
module gcode_line_bounding_box_unit #(
  parameter int MAX_LINE = 256
) (
  input logic         clk,
  input logic         rst,
  gclbb_in_if.sink    item,
  gclbb_out_if.source result
);
  import gclbb_pkg::*;

  localparam int PosW = $clog2(MAX_LINE);
  localparam logic [PosW-1:0] PosLimit = PosW'(MAX_LINE - 1);

  typedef enum logic [1:0] {ScanNormal, ScanX, ScanY} scan_t;

  // input register
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_ch;

  // box and line state
  coord_t bxl, bxh, byl, byh;
  coord_t pxl, pxh, pyl, pyh;
  logic [1:0] pvalid;
  logic   motion, after_g;
  scan_t  scan;
  num_t   num;
  logic [PosW-1:0] pos;

  coord_t bxl_next, bxh_next, byl_next, byh_next;
  coord_t pxl_next, pxh_next, pyl_next, pyh_next;
  logic [1:0] pvalid_next;
  logic   motion_next, after_g_next;
  scan_t  scan_next;
  num_t   num_next;
  logic [PosW-1:0] pos_next;

  num_t   num_step;
  coord_t word_value;
  coord_t fxl, fxh, fyl, fyh;
  logic [1:0] fvalid;
  logic   word_end, produce, s1_fire;

  // result register
  logic   res_valid;
  coord_t res_xl, res_xh, res_yl, res_yh;
  logic   res_counted;

  gclbb_num u_num (
    .cur   (num),
    .ch    (s1_ch),
    .nxt   (num_step),
    .value (word_value)
  );

  assign produce = (s1_op == OpByte) && (s1_ch == ChLf);
  assign s1_fire = s1_valid && (!produce || !res_valid || result.ready);
  assign item.ready = !s1_valid || s1_fire;

  assign word_end = (scan != ScanNormal)
                  && (s1_ch == ChLf || s1_ch == ChSpace || s1_ch == ChCr);

  // line extremes with the word that ends at this byte folded in
  always_comb begin
    fxl    = pxl;
    fxh    = pxh;
    fyl    = pyl;
    fyh    = pyh;
    fvalid = pvalid;
    if (word_end && scan == ScanX) begin
      fvalid[0] = 1'b1;
      if (!pvalid[0]) begin
        fxl = word_value;
        fxh = word_value;
      end else begin
        if (word_value < pxl) fxl = word_value;
        if (word_value > pxh) fxh = word_value;
      end
    end
    if (word_end && scan == ScanY) begin
      fvalid[1] = 1'b1;
      if (!pvalid[1]) begin
        fyl = word_value;
        fyh = word_value;
      end else begin
        if (word_value < pyl) fyl = word_value;
        if (word_value > pyh) fyh = word_value;
      end
    end
  end

  always_comb begin
    bxl_next = bxl;  bxh_next = bxh;  byl_next = byl;  byh_next = byh;
    pxl_next = pxl;  pxh_next = pxh;  pyl_next = pyl;  pyh_next = pyh;
    pvalid_next  = pvalid;
    motion_next  = motion;
    after_g_next = after_g;
    scan_next    = scan;
    num_next     = num;
    pos_next     = pos;
    if (s1_op == OpClear) begin
      bxl_next = '0;  bxh_next = '0;  byl_next = '0;  byh_next = '0;
      pxl_next = '0;  pxh_next = '0;  pyl_next = '0;  pyh_next = '0;
      pvalid_next  = '0;
      motion_next  = 1'b0;
      after_g_next = 1'b0;
      scan_next    = ScanNormal;
      num_next     = '0;
      pos_next     = '0;
    end else begin
      if (after_g && (s1_ch == ChZero || s1_ch == ChOne)) motion_next = 1'b1;
      after_g_next = (s1_ch == ChG);
      if (s1_ch == ChLf) begin
        if (motion_next) begin
          if (fvalid[0]) begin
            if (fxl < bxl) bxl_next = fxl;
            if (fxh > bxh) bxh_next = fxh;
          end
          if (fvalid[1]) begin
            if (fyl < byl) byl_next = fyl;
            if (fyh > byh) byh_next = fyh;
          end
        end
        pxl_next = '0;  pxh_next = '0;  pyl_next = '0;  pyh_next = '0;
        pvalid_next  = '0;
        motion_next  = 1'b0;
        after_g_next = 1'b0;
        scan_next    = ScanNormal;
        num_next     = '0;
        pos_next     = '0;
      end else if (scan != ScanNormal) begin
        if (word_end) begin
          pxl_next = fxl;  pxh_next = fxh;  pyl_next = fyl;  pyh_next = fyh;
          pvalid_next = fvalid;
          scan_next   = ScanNormal;
          num_next    = '0;
          if (pos < PosLimit) pos_next = pos + 1'b1;
        end else begin
          num_next = num_step;
        end
      end else if (pos < PosLimit) begin
        if (s1_ch == ChX) begin
          scan_next = ScanX;
          num_next  = '0;
        end else if (s1_ch == ChY) begin
          scan_next = ScanY;
          num_next  = '0;
        end else begin
          pos_next = pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      bxl <= '0;  bxh <= '0;  byl <= '0;  byh <= '0;
      pxl <= '0;  pxh <= '0;  pyl <= '0;  pyh <= '0;
      pvalid  <= '0;
      motion  <= 1'b0;
      after_g <= 1'b0;
      scan    <= ScanNormal;
      num     <= '0;
      pos     <= '0;
    end else begin
      if (item.ready) begin
        s1_valid <= item.valid;
      end
      if (s1_fire) begin
        bxl <= bxl_next;  bxh <= bxh_next;  byl <= byl_next;  byh <= byh_next;
        pxl <= pxl_next;  pxh <= pxh_next;  pyl <= pyl_next;  pyh <= pyh_next;
        pvalid  <= pvalid_next;
        motion  <= motion_next;
        after_g <= after_g_next;
        scan    <= scan_next;
        num     <= num_next;
        pos     <= pos_next;
      end
      if (s1_fire && produce) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_op <= item.op;
      s1_ch <= item.ch;
    end
    if (s1_fire && produce) begin
      res_xl      <= bxl_next;
      res_xh      <= bxh_next;
      res_yl      <= byl_next;
      res_yh      <= byh_next;
      res_counted <= motion && !(s1_op == OpClear);
    end
  end

  assign result.valid        = res_valid;
  assign result.box_x_min    = res_xl;
  assign result.box_x_max    = res_xh;
  assign result.box_y_min    = res_yl;
  assign result.box_y_max    = res_yh;
  assign result.line_counted = res_counted;

`ifndef SYNTHESIS
  // the box always holds the origin
  a_box_origin: assert property (@(posedge clk) disable iff (rst)
    bxl <= 0 && bxh >= 0 && byl <= 0 && byh >= 0)
    else $error("bounding box lost the origin");

  a_mag_cap: assert property (@(posedge clk) disable iff (rst)
    num.accum <= MagCap)
    else $error("number magnitude above cap");

  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    pos <= PosLimit)
    else $error("position count above limit");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    s1_fire && produce |=> result.valid)
    else $error("newline request produced no result");
`endif

endmodule

// File: tb/gclbb_box_checker.sv
`timescale 1ns / 1ps
// Checker for the G-code bounding box unit: follows every accepted request,
// predicts the box report of each LF and compares it with the result channel.
// Depends on gclbb_pkg, gclbb_in_if and gclbb_out_if.
module gclbb_box_checker #(
  parameter int MAX_LINE = 256
) (
  input  logic clk,
  input  logic rst,
  gclbb_in_if  req_bus,
  gclbb_out_if box_bus,
  output int   fail_count,
  output int   open_results
);
  import gclbb_pkg::*;

  typedef enum logic [1:0] {
    ScanNone = 2'd0,
    ScanX    = 2'd1,
    ScanY    = 2'd2
  } scan_t;

  typedef struct packed {
    coord_t x_min;
    coord_t x_max;
    coord_t y_min;
    coord_t y_max;
    logic   counted;
  } box_t;

  box_t box_due[$];

  // running box and per-line extremes
  coord_t     bx_lo, bx_hi, by_lo, by_hi;
  coord_t     lx_lo, lx_hi, ly_lo, ly_hi;
  logic [1:0] seen_xy;
  logic       motion;
  logic       prev_g;
  scan_t      scan;
  int         pos_cnt;

  // number being parsed
  mag_t       acc;
  logic       neg, dot, stop, begun;
  logic [1:0] fcnt;

  task automatic clear_num();
    acc   = '0;
    neg   = 1'b0;
    dot   = 1'b0;
    stop  = 1'b0;
    begun = 1'b0;
    fcnt  = '0;
  endtask

  task automatic clear_line();
    lx_lo   = '0;
    lx_hi   = '0;
    ly_lo   = '0;
    ly_hi   = '0;
    seen_xy = '0;
    motion  = 1'b0;
    prev_g  = 1'b0;
    scan    = ScanNone;
    pos_cnt = 0;
    clear_num();
  endtask

  task automatic clear_box();
    bx_lo = '0;
    bx_hi = '0;
    by_lo = '0;
    by_hi = '0;
    clear_line();
  endtask

  task automatic close_word();
    coord_t v;
    if (neg) v = coord_t'(-acc);
    else v = (acc > mag_t'(PosCap)) ? PosCap : coord_t'(acc);
    if (scan == ScanX) begin
      if (!seen_xy[0]) begin
        lx_lo = v;
        lx_hi = v;
      end else begin
        if (v < lx_lo) lx_lo = v;
        if (v > lx_hi) lx_hi = v;
      end
      seen_xy[0] = 1'b1;
    end else if (scan == ScanY) begin
      if (!seen_xy[1]) begin
        ly_lo = v;
        ly_hi = v;
      end else begin
        if (v < ly_lo) ly_lo = v;
        if (v > ly_hi) ly_hi = v;
      end
      seen_xy[1] = 1'b1;
    end
    scan = ScanNone;
    clear_num();
  endtask

  task automatic track_byte(input logic op, input logic [7:0] ch);
    logic [31:0] grown;
    logic [3:0]  digit;
    logic [6:0]  weight;
    if (op == OpClear) begin
      clear_box();
    end else begin
      if (prev_g && (ch == ChZero || ch == ChOne)) motion = 1'b1;
      prev_g = (ch == ChG);
      if (ch == ChLf) begin
        if (scan != ScanNone) close_word();
        if (motion) begin
          if (seen_xy[0]) begin
            if (lx_lo < bx_lo) bx_lo = lx_lo;
            if (lx_hi > bx_hi) bx_hi = lx_hi;
          end
          if (seen_xy[1]) begin
            if (ly_lo < by_lo) by_lo = ly_lo;
            if (ly_hi > by_hi) by_hi = ly_hi;
          end
        end
        box_due.push_back('{bx_lo, bx_hi, by_lo, by_hi, motion});
        clear_line();
      end else if (scan != ScanNone) begin
        if (ch == ChSpace || ch == ChCr) begin
          close_word();
          if (pos_cnt < MAX_LINE - 1) pos_cnt++;
        end else if (!stop) begin
          if ((ch == ChPlus || ch == ChMinus) && !begun) begin
            if (ch == ChMinus) neg = 1'b1;
          end else if (ch >= ChZero && ch <= ChNine) begin
            digit = 4'(ch - ChZero);
            grown = 32'(acc);
            if (!dot) begin
              grown = 32'(acc) * 32'd10 + 32'(digit) * 32'd1000;
            end else if (fcnt < FracMax) begin
              case (fcnt)
                2'd0:    weight = 7'd100;
                2'd1:    weight = 7'd10;
                default: weight = 7'd1;
              endcase
              grown = 32'(acc) + 32'(digit) * 32'(weight);
              fcnt++;
            end
            if (grown > 32'(MagCap)) grown = 32'(MagCap);
            acc = grown[CoordW-1:0];
          end else if (ch == ChDot && !dot) begin
            dot = 1'b1;
          end else begin
            stop = 1'b1;
          end
          begun = 1'b1;
        end
      end else if (pos_cnt < MAX_LINE - 1) begin
        if (ch == ChX) begin
          scan = ScanX;
          clear_num();
        end else if (ch == ChY) begin
          scan = ScanY;
          clear_num();
        end else begin
          pos_cnt++;
        end
      end
    end
  endtask

  task automatic log_fail(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  always @(posedge clk) begin : watch
    box_t got, want;
    if (rst) begin
      clear_box();
      box_due.delete();
      fail_count = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) track_byte(req_bus.op, req_bus.ch);
      if (box_bus.valid && box_bus.ready) begin
        got = '{box_bus.box_x_min, box_bus.box_x_max, box_bus.box_y_min,
                box_bus.box_y_max, box_bus.line_counted};
        if (box_due.size() == 0) begin
          log_fail($sformatf("unexpected box: %0d %0d %0d %0d counted %0b",
                             $signed(got.x_min), $signed(got.x_max),
                             $signed(got.y_min), $signed(got.y_max), got.counted));
        end else begin
          want = box_due.pop_front();
          if (got.x_min !== want.x_min || got.x_max !== want.x_max ||
              got.y_min !== want.y_min || got.y_max !== want.y_max ||
              got.counted !== want.counted) begin
            log_fail($sformatf({"box mismatch: exp %0d %0d %0d %0d c%0b",
                                " got %0d %0d %0d %0d c%0b"},
                               $signed(want.x_min), $signed(want.x_max),
                               $signed(want.y_min), $signed(want.y_max), want.counted,
                               $signed(got.x_min), $signed(got.x_max),
                               $signed(got.y_min), $signed(got.y_max), got.counted));
          end
        end
      end
    end
    open_results = box_due.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the bounding box testbench: clock, reset, byte stimulus and the
// result sink; the verdict uses the counts from gclbb_box_checker.
// Depends on gclbb_pkg, both channel interfaces, the unit and the checker.
module tb;
  import gclbb_pkg::*;

  localparam int MaxLine    = 256;
  localparam int ItemTarget = 700;
  localparam int MinLines   = 40;
  localparam int HoldCycles = 400;
  localparam int CycleLimit = 200000;

  logic clk;
  logic rst;
  int   fail_count;
  int   open_results;
  int   sent_count;
  int   cycles;
  logic steady;
  logic hold_go;
  logic hold_done;

  logic [7:0] text_q[$];

  string motion_words[6] = '{"G0", "G1", "G01", "G2", "G28", "g1"};
  string other_words[5]  = '{"F1500", "M3", "S100", "Z1.5", "x4"};

  gclbb_in_if  item_bus ();
  gclbb_out_if box_bus ();

  gcode_line_bounding_box_unit #(.MAX_LINE(MaxLine)) uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (box_bus)
  );

  gclbb_box_checker #(.MAX_LINE(MaxLine)) box_check (
    .clk          (clk),
    .rst          (rst),
    .req_bus      (item_bus),
    .box_bus      (box_bus),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // sign, integer digits, optional fraction, sometimes a stray character
  task automatic push_number();
    int    n_int;
    string junk;
    junk = "-.+e";
    case ($urandom_range(0, 3))
      0:       text_q.push_back(ChMinus);
      1:       text_q.push_back(ChPlus);
      default: ;
    endcase
    n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 4);
    repeat (n_int) text_q.push_back(ChZero + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 2) != 0) begin
      text_q.push_back(ChDot);
      repeat ($urandom_range(0, 5)) text_q.push_back(ChZero + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) == 0) text_q.push_back(junk[$urandom_range(0, 3)]);
  endtask

  task automatic send_req(input logic op_v, input logic [7:0] ch_v);
    while (!steady && $urandom_range(0, 99) < 37) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.op    <= op_v;
    item_bus.ch    <= ch_v;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_queue();
    foreach (text_q[i]) send_req(OpByte, text_q[i]);
    text_q.delete();
  endtask

  // result sink: random back-pressure plus one long hold-off
  initial begin
    box_bus.ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        box_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      box_bus.ready <= steady || ($urandom_range(0, 99) >= 37);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int line_no;
    int kind;
    rst            <= 1'b1;
    item_bus.valid <= 1'b0;
    item_bus.op    <= OpByte;
    item_bus.ch    <= 8'h00;
    steady     = 1'b0;
    hold_go    = 1'b0;
    sent_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: most negative value, LF closing a word
    push_text("G1X-8388.608\n");
    // positive saturation, fourth fraction digit, second dot, late sign, empty word
    push_text("G0 Y+99999.9999 X1.2.3 X-2-");
    text_q.push_back(ChCr);
    push_text(" Y\n");
    // line without motion, byte extremes
    push_text("X7 Y-7");
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    push_text("\n");
    // lowercase is not a command or a word
    push_text("g1 x9\n");
    send_queue();
    send_req(OpClear, 8'hA5);
    push_text("G1 X\n");
    send_queue();

    hold_go = 1'b1;
    line_no = 0;
    while (sent_count < ItemTarget || line_no < MinLines) begin
      steady = (sent_count >= 350 && sent_count < 470);
      if ($urandom_range(0, 29) == 0) send_req(OpClear, 8'($urandom_range(0, 255)));
      if (line_no == 8) begin
        // crosses the position limit near its end
        push_text("G1 X");
        push_number();
        text_q.push_back(ChSpace);
        repeat ($urandom_range(245, 262)) text_q.push_back(ChSpace);
        text_q.push_back(ChX);
        push_number();
        push_text(" Y");
        push_number();
        text_q.push_back(ChLf);
      end else begin
        if ($urandom_range(0, 9) < 7) push_text($urandom_range(0, 1) ? "G1 " : "G0 ");
        repeat ($urandom_range(1, 5)) begin
          kind = $urandom_range(0, 99);
          if (kind < 15) begin
            push_text(motion_words[$urandom_range(0, 5)]);
          end else if (kind < 65) begin
            text_q.push_back($urandom_range(0, 1) ? ChX : ChY);
            push_number();
          end else if (kind < 80) begin
            push_text(other_words[$urandom_range(0, 4)]);
          end else begin
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
          end
          case ($urandom_range(0, 9))
            0:       ;
            1:       text_q.push_back(ChCr);
            default: text_q.push_back(ChSpace);
          endcase
        end
        if ($urandom_range(0, 3) == 0) text_q.push_back(ChCr);
        text_q.push_back(ChLf);
      end
      send_queue();
      line_no++;
    end
    steady = 1'b0;
    item_bus.valid <= 1'b0;

    while (open_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
